@@ src/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants for the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int MAX_KEYS_DEF = 256;

	localparam int TIME_W   = 32;
	localparam int COMP_W   = 32;
	localparam int VEC_W    = 3 * COMP_W;
	localparam int INDEX_W  = 8;
	localparam int SEG_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// s_tdata: key_index, key_time, value_x, value_y, value_z, sample_time
	localparam int IN_DATA_W  = INDEX_W + 5 * TIME_W;
	// m_tdata: out_x, out_y, out_z, segment
	localparam int OUT_DATA_W = VEC_W + SEG_W;

	localparam int FRAC_W = 16;
	localparam int ALU_W  = 50;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_INTERP   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_HOLD     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LOOK0,
		ST_SRCH,
		ST_NUM,
		ST_DEN,
		ST_DIV,
		ST_DELTA,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} kts_state_t;

endpackage

@@ src/keyframe_track_sampler.sv @@
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe table with linear search and Q16.16 linear interpolation of a
// 3-component vector, computed on one shared adder under a sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  signals                         carries
//  s_        in         s_tvalid s_tready s_tdata s_tuser key write or sample
//  m_        out        m_tvalid m_tready m_tdata m_tuser sampled vector
//  cfg_      in         cfg_valid cfg_ready cfg_data     key_count
//
//  A key write does not occupy the sequencer; the block stays ready.
//  A sample reads one table entry per key visited in the search, then runs
//  16 divide steps for the fraction, then per component a delta, a
//  shift-add multiply and a final add, all on one adder.
//  A held result (before first key, after last key) ends after the search.
//  No clearing pass after reset; key_count resets to 1.
//  A stalled result register blocks the end of the next sample only.
// ----------------------------------------------------------------------------
module keyframe_track_sampler
	import kts_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key_index, key_time, value_x, value_y, value_z, sample_time
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_x, out_y, out_z, segment
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [STATUS_W-1:0]   m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int NW = AW + 1;

	kts_state_t state_q, state_d;

	logic [COUNT_W-1:0]    key_count_q;
	logic [TIME_W-1:0]     t_q, t0_q, t1_q, rem_q, den_q;
	logic [NW-1:0]         n_q;
	logic [AW-1:0]         i_q;
	logic [VEC_W-1:0]      va_q, vb_q, res_q;
	logic [SEG_W-1:0]      res_seg_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [FRAC_W-1:0]     frac_q, mq_q;
	logic [3:0]            cnt_q;
	logic [1:0]            comp_q;
	logic [COMP_W:0]       delta_q;
	logic [COMP_W+FRAC_W:0] acc_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  m_tvalid_q;

	logic [INDEX_W-1:0] key_index;
	logic [TIME_W-1:0]  key_time, sample_time;
	logic [VEC_W-1:0]   key_vec;

	logic            in_acc, wr_en;
	logic [AW-1:0]   rd_addr;
	logic [TIME_W-1:0] rd_time;
	logic [VEC_W-1:0]  rd_vec;

	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic             alu_sub;
	logic             borrow;
	logic             out_free;

	assign key_index   = s_tdata[INDEX_W-1:0];
	assign key_time    = s_tdata[INDEX_W +: TIME_W];
	assign key_vec     = s_tdata[INDEX_W+TIME_W +: VEC_W];
	assign sample_time = s_tdata[INDEX_W+TIME_W+VEC_W +: TIME_W];

	assign in_acc   = s_tvalid && s_tready;
	assign wr_en    = in_acc && (s_tuser == KIND_WRITE) && (32'(key_index) < 32'(MAX_KEYS));
	assign out_free = !m_tvalid_q || m_tready;

	function automatic logic [COMP_W-1:0] pick(input logic [VEC_W-1:0] v, input logic [1:0] c);
		logic [COMP_W-1:0] r;
		case (c)
			2'd1:    r = v[COMP_W +: COMP_W];
			2'd2:    r = v[2*COMP_W +: COMP_W];
			default: r = v[COMP_W-1:0];
		endcase
		return r;
	endfunction

	function automatic logic [NW-1:0] sat_count(input logic [COUNT_W-1:0] kc);
		logic [NW-1:0] r;
		if (kc == '0) begin
			r = NW'(1);
		end else if (32'(kc) > 32'(MAX_KEYS)) begin
			r = NW'(MAX_KEYS);
		end else begin
			r = NW'(kc);
		end
		return r;
	endfunction

	kts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(key_index)),
		.wdata (key_time),
		.raddr (rd_addr),
		.rdata (rd_time)
	);

	kts_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KEYS)) u_value_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(key_index)),
		.wdata (key_vec),
		.raddr (rd_addr),
		.rdata (rd_vec)
	);

	// shared adder / subtractor
	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign borrow  = alu_res[ALU_W-1];

	// outputs of the sequencer: adder operands and table address
	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		rd_addr  = AW'({1'b0, i_q} + NW'(2));
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_FIRST: begin
				rd_addr = '0;
			end
			ST_LOOK0: begin
				rd_addr = AW'(1);
				alu_a   = ALU_W'(t_q);
				alu_b   = ALU_W'(rd_time);
				alu_sub = 1'b1;
			end
			ST_SRCH: begin
				alu_a   = ALU_W'(t_q);
				alu_b   = ALU_W'(rd_time);
				alu_sub = 1'b1;
			end
			ST_NUM: begin
				alu_a   = ALU_W'(t_q);
				alu_b   = ALU_W'(t0_q);
				alu_sub = 1'b1;
			end
			ST_DEN: begin
				alu_a   = ALU_W'(t1_q);
				alu_b   = ALU_W'(t0_q);
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = ALU_W'({rem_q, 1'b0});
				alu_b   = ALU_W'(den_q);
				alu_sub = 1'b1;
			end
			ST_DELTA: begin
				alu_a   = ALU_W'($signed(pick(vb_q, comp_q)));
				alu_b   = ALU_W'($signed(pick(va_q, comp_q)));
				alu_sub = 1'b1;
			end
			ST_MUL: begin
				alu_a = ALU_W'({acc_q, 1'b0});
				alu_b = mq_q[FRAC_W-1] ? ALU_W'($signed(delta_q)) : '0;
			end
			ST_FIN: begin
				// floor of acc / 2^16 is the arithmetic shift
				alu_a = ALU_W'($signed(pick(va_q, comp_q)));
				alu_b = ALU_W'($signed(acc_q[COMP_W+FRAC_W:FRAC_W]));
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == KIND_SAMPLE) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: state_d = ST_LOOK0;
			ST_LOOK0: begin
				if (n_q == NW'(1) || borrow) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (borrow) begin
					state_d = ST_NUM;
				end else if (({1'b0, i_q} + NW'(2)) >= n_q) begin
					state_d = ST_OUT;
				end
			end
			ST_NUM: state_d = ST_DEN;
			ST_DEN: begin
				if (borrow || alu_res[TIME_W-1:0] == '0) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == 4'd15) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == 4'd15) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (comp_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_DELTA;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= COUNT_W'(1);
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				key_count_q <= cfg_data;
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q <= sample_time;
				n_q <= sat_count(key_count_q);
			end
			ST_LOOK0: begin
				t0_q         <= rd_time;
				va_q         <= rd_vec;
				i_q          <= '0;
				res_q        <= rd_vec;
				res_seg_q    <= '0;
				res_status_q <= STATUS_HOLD;
			end
			ST_SRCH: begin
				if (borrow) begin
					t1_q <= rd_time;
					vb_q <= rd_vec;
				end else begin
					i_q          <= i_q + AW'(1);
					t0_q         <= rd_time;
					va_q         <= rd_vec;
					res_q        <= rd_vec;
					res_seg_q    <= SEG_W'(i_q + AW'(1));
					res_status_q <= STATUS_HOLD;
				end
			end
			ST_NUM: begin
				rem_q <= alu_res[TIME_W-1:0];
			end
			ST_DEN: begin
				den_q        <= alu_res[TIME_W-1:0];
				res_q        <= va_q;
				res_seg_q    <= SEG_W'(i_q);
				res_status_q <= STATUS_ZERO_LEN;
				cnt_q        <= '0;
				comp_q       <= '0;
			end
			ST_DIV: begin
				frac_q <= {frac_q[FRAC_W-2:0], ~borrow};
				rem_q  <= borrow ? {rem_q[TIME_W-2:0], 1'b0} : alu_res[TIME_W-1:0];
				cnt_q  <= cnt_q + 4'd1;
			end
			ST_DELTA: begin
				delta_q <= alu_res[COMP_W:0];
				acc_q   <= '0;
				mq_q    <= frac_q;
				cnt_q   <= '0;
			end
			ST_MUL: begin
				acc_q <= alu_res[COMP_W+FRAC_W:0];
				mq_q  <= {mq_q[FRAC_W-2:0], 1'b0};
				cnt_q <= cnt_q + 4'd1;
			end
			ST_FIN: begin
				case (comp_q)
					2'd1:    res_q[COMP_W +: COMP_W]   <= alu_res[COMP_W-1:0];
					2'd2:    res_q[2*COMP_W +: COMP_W] <= alu_res[COMP_W-1:0];
					default: res_q[COMP_W-1:0]         <= alu_res[COMP_W-1:0];
				endcase
				comp_q       <= comp_q + 2'd1;
				res_status_q <= STATUS_INTERP;
				res_seg_q    <= SEG_W'(i_q);
			end
			ST_OUT: begin
				if (out_free) begin
					out_data_q   <= {res_seg_q, res_q};
					out_status_q <= res_status_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_status_q;

endmodule

@@ src/kts_ram.sv @@
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/kts_checker.sv @@
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks of the keyframe track sampler, bound to the top level.
// ----------------------------------------------------------------------------
module kts_checker
	import kts_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]   m_tuser
);

	// stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a sample transfer occupies the sequencer
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_SAMPLE |=> !s_tready)
		else $error("ready right after a sample transfer");

	// a key write completes in its own cycle
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_WRITE |=> s_tready)
		else $error("ready dropped after a key write");

	// a new result comes only out of a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (.*);

@@ verif/keyframe_track_sampler_test.sv @@
// ----------------------------------------------------------------------------
// keyframe_track_sampler_test
// Self-checking bench for the keyframe track sampler. Key writes and sample
// queries stream in from a queue with random gaps, sampled vectors are
// drained with random back-pressure, and every sample is checked field by
// field against a local track model that follows each accepted transfer.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_test
	import kts_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES    = 2_000_000;
	localparam int RANDOM_ITEMS    = 700;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 400;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] key_index;
		logic [TIME_W-1:0]  key_time;
		logic [COMP_W-1:0]  value_x;
		logic [COMP_W-1:0]  value_y;
		logic [COMP_W-1:0]  value_z;
		logic [TIME_W-1:0]  sample_time;
	} track_item_t;

	typedef struct packed {
		logic [COMP_W-1:0]   out_x;
		logic [COMP_W-1:0]   out_y;
		logic [COMP_W-1:0]   out_z;
		logic [SEG_W-1:0]    segment;
		logic [STATUS_W-1:0] status;
	} track_sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data = '0;

	keyframe_track_sampler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// local copy of the block's table and register
	logic [TIME_W-1:0]  track_time [MAX_KEYS_DEF];
	logic [COMP_W-1:0]  track_vec  [MAX_KEYS_DEF][3];
	logic [COUNT_W-1:0] key_count_cfg = 1;
	track_sample_t      expected_samples [$];

	// stimulus side view of key times, used to aim sample times
	logic [TIME_W-1:0]  gen_time [MAX_KEYS_DEF];
	track_item_t        pending_items [$];

	track_item_t drv_item = '0;
	bit          drv_busy = 1'b0;
	int          drv_gap = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	int          sink_wait = 0;
	bit          hold_off_req = 1'b0;
	bit          hold_off_done = 1'b0;
	int          hold_off_left = 0;
	bit          in_xfer = 1'b0;
	bit          out_xfer = 1'b0;

	int mismatch_count = 0;
	int cycle_count = 0;
	int keys_written = 0;
	int samples_checked = 0;
	int interp_seen = 0;
	int hold_seen = 0;
	int settings_used = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [COMP_W-1:0] lerp_comp(input logic [COMP_W-1:0] start_v,
			input logic [COMP_W-1:0] end_v, input longint frac);
		longint a;
		longint b;
		longint d;
		a = $signed(start_v);
		b = $signed(end_v);
		// arithmetic shift gives the floor of the scaled delta
		d = a + (((b - a) * frac) >>> FRAC_W);
		return d[COMP_W-1:0];
	endfunction

	function automatic track_sample_t sample_track(input logic [TIME_W-1:0] t);
		track_sample_t    r;
		int               n;
		int               seg;
		longint unsigned  num;
		longint unsigned  den;
		longint           frac;
		if (key_count_cfg == 0)
			n = 1;
		else if (key_count_cfg > MAX_KEYS_DEF)
			n = MAX_KEYS_DEF;
		else
			n = int'(key_count_cfg);
		seg = 0;
		r.status = STATUS_HOLD;
		if (n > 1 && t >= track_time[0]) begin
			while (seg + 1 < n && t >= track_time[seg + 1])
				seg++;
			if (seg + 1 >= n)
				seg = n - 1;
			else if (track_time[seg + 1] <= track_time[seg])
				r.status = STATUS_ZERO_LEN;
			else
				r.status = STATUS_INTERP;
		end
		r.segment = seg[SEG_W-1:0];
		r.out_x = track_vec[seg][0];
		r.out_y = track_vec[seg][1];
		r.out_z = track_vec[seg][2];
		if (r.status == STATUS_INTERP) begin
			num = t - track_time[seg];
			den = track_time[seg + 1] - track_time[seg];
			frac = longint'((num << FRAC_W) / den);
			r.out_x = lerp_comp(track_vec[seg][0], track_vec[seg + 1][0], frac);
			r.out_y = lerp_comp(track_vec[seg][1], track_vec[seg + 1][1], frac);
			r.out_z = lerp_comp(track_vec[seg][2], track_vec[seg + 1][2], frac);
		end
		return r;
	endfunction

	function automatic void apply_item(input track_item_t it);
		if (it.kind == KIND_WRITE) begin
			if (it.key_index < MAX_KEYS_DEF) begin
				track_time[it.key_index]   = it.key_time;
				track_vec[it.key_index][0] = it.value_x;
				track_vec[it.key_index][1] = it.value_y;
				track_vec[it.key_index][2] = it.value_z;
			end
			keys_written++;
		end else begin
			expected_samples.insert(expected_samples.size(), sample_track(it.sample_time));
		end
	endfunction

	task automatic compare_field(input string name, input logic [COMP_W-1:0] exp_v,
			input logic [COMP_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	task automatic check_sample();
		track_sample_t got;
		track_sample_t want;
		got.out_x   = m_tdata[COMP_W-1:0];
		got.out_y   = m_tdata[2*COMP_W-1:COMP_W];
		got.out_z   = m_tdata[VEC_W-1:2*COMP_W];
		got.segment = m_tdata[OUT_DATA_W-1:VEC_W];
		got.status  = m_tuser;
		if (expected_samples.size() == 0) begin
			$display("%0t: unexpected sample, expected none, got %h", $time, got);
			mismatch_count++;
		end else begin
			want = expected_samples.pop_front();
			compare_field("out_x", want.out_x, got.out_x);
			compare_field("out_y", want.out_y, got.out_y);
			compare_field("out_z", want.out_z, got.out_z);
			compare_field("segment", COMP_W'(want.segment), COMP_W'(got.segment));
			compare_field("status", COMP_W'(want.status), COMP_W'(got.status));
			samples_checked++;
			if (want.status == STATUS_INTERP)
				interp_seen++;
			else
				hold_seen++;
		end
	endtask

	// both handshakes are sampled here; the driver and sink act on them at the falling edge
	always @(posedge clk) begin
		in_xfer  = arst_n && s_tvalid && s_tready;
		out_xfer = arst_n && m_tvalid && m_tready;
		if (in_xfer)
			apply_item(drv_item);
		if (out_xfer)
			check_sample();
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d samples outstanding", $time,
				cycle_count, expected_samples.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (drv_busy && in_xfer) begin
			drv_busy = 1'b0;
			drv_gap = src_idle_on ? $urandom_range(0, 7) : 0;
		end
		if (!drv_busy) begin
			if (drv_gap > 0)
				drv_gap--;
			else if (pending_items.size() != 0) begin
				drv_item = pending_items.pop_front();
				drv_busy = 1'b1;
			end
		end
		s_tvalid <= drv_busy;
		s_tdata  <= {drv_item.sample_time, drv_item.value_z, drv_item.value_y,
			drv_item.value_x, drv_item.key_time, drv_item.key_index};
		s_tuser  <= drv_item.kind;
	end

	always @(negedge clk) begin
		// one long hold-off lets the result path back up into the input
		if (hold_off_req && !hold_off_done) begin
			hold_off_left = HOLD_OFF_CYCLES;
			hold_off_done = 1'b1;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			m_tready <= 1'b0;
		end else begin
			if (out_xfer)
				sink_wait = sink_idle_on ? $urandom_range(0, 7) : 0;
			else if (sink_wait > 0)
				sink_wait--;
			m_tready <= (sink_wait == 0);
		end
	end

	function automatic logic [COMP_W-1:0] rand_comp();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_key(input int idx, input logic [TIME_W-1:0] t,
			input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
			input logic [COMP_W-1:0] z);
		track_item_t it;
		it.kind        = KIND_WRITE;
		it.key_index   = idx[INDEX_W-1:0];
		it.key_time    = t;
		it.value_x     = x;
		it.value_y     = y;
		it.value_z     = z;
		it.sample_time = $urandom;
		gen_time[idx]  = t;
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void queue_sample(input logic [TIME_W-1:0] t);
		track_item_t it;
		it.kind        = KIND_SAMPLE;
		it.key_index   = INDEX_W'($urandom);
		it.key_time    = $urandom;
		it.value_x     = $urandom;
		it.value_y     = $urandom;
		it.value_z     = $urandom;
		it.sample_time = t;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// keys 0..n-1 with strictly increasing times
	function automatic void load_track(input int n);
		longint unsigned t;
		longint unsigned span;
		longint unsigned gmax;
		case ($urandom_range(0, 3))
			0: t = 0;
			1: t = $urandom_range(0, 65535);
			2: t = $urandom_range(0, 32'h7FFF_FFFF);
			default: t = $urandom;
		endcase
		span = (64'hFFFF_FFFF - t) / n;
		if (span < 4) begin
			t = 0;
			span = 64'hFFFF_FFFF / n;
		end
		case ($urandom_range(0, 2))
			0: gmax = 4;
			1: gmax = 32'h0004_0000;
			default: gmax = 32'hFFFF_FFFF;
		endcase
		if (gmax > span)
			gmax = span;
		for (int k = 0; k < n; k++) begin
			queue_key(k, TIME_W'(t), rand_comp(), rand_comp(), rand_comp());
			t += $urandom_range(1, 32'(gmax));
		end
	endfunction

	function automatic logic [TIME_W-1:0] pick_sample_time(input int n);
		longint unsigned lo;
		longint unsigned hi;
		int k;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2, 3: return gen_time[k];
			4: return gen_time[k] - 1;
			5: return $urandom;
			6: return gen_time[0] - $urandom_range(1, 256);
			7: return gen_time[n - 1] + $urandom_range(0, 256);
			default: begin
				if (n < 2)
					return $urandom;
				k = $urandom_range(0, n - 2);
				lo = gen_time[k];
				hi = gen_time[k + 1];
				if (hi <= lo)
					return $urandom;
				return TIME_W'(lo + ({$urandom, $urandom} % (hi - lo)));
			end
		endcase
	endfunction

	// everything accepted and every sample back, then a settling wait for a trailing key write
	task automatic wait_drained();
		while (pending_items.size() != 0 || drv_busy || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_count(input logic [COUNT_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		key_count_cfg = v;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          phase;
		int          random_items;
		int          n_eff;
		int          n_items;
		int          r;
		int          k;
		bit          reload;
		logic [COUNT_W-1:0] cfg_val;
		logic [TIME_W-1:0]  t;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single key after reset, then key_count zero acts as one
		queue_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		queue_sample(32'h0000_0000);
		queue_sample(32'hFFFF_FFFF);
		set_key_count(0);
		queue_sample(32'h0001_2345);

		// four keys with full-scale swings between them
		set_key_count(4);
		queue_key(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_key(2, 32'h0003_0000, 32'h4000_0000, 32'hC000_0000, 32'h0001_0000);
		queue_key(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		queue_sample(32'h0000_0000);
		queue_sample(32'h0001_0000);
		queue_sample(32'h0001_8000);
		queue_sample(32'h0001_FFFF);
		queue_sample(32'h0002_0000);
		queue_sample(32'hFFFF_FFFE);
		queue_sample(32'hFFFF_FFFF);
		// equal and then decreasing key times
		queue_key(2, 32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
		queue_sample(32'h0002_0000);
		queue_sample(32'h0002_0001);
		queue_key(1, 32'h0000_8000, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
		queue_sample(32'h0000_9000);
		queue_sample(32'h0001_0000);
		queue_key(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 0) begin
				cfg_val = 511;
				reload = 1'b1;
			end else if (phase == 1) begin
				cfg_val = 256;
				reload = 1'b0;
			end else if (phase == 2) begin
				cfg_val = 5;
				reload = 1'b1;
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0)
					cfg_val = COUNT_W'($urandom_range(0, 1));
				else if (r == 1)
					cfg_val = COUNT_W'($urandom_range(17, 64));
				else if (r == 2)
					cfg_val = COUNT_W'($urandom_range(257, 511));
				else
					cfg_val = COUNT_W'($urandom_range(2, 16));
				reload = (cfg_val <= 64) || ($urandom_range(0, 3) == 0);
			end
			set_key_count(cfg_val);
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			if (cfg_val == 0)
				n_eff = 1;
			else if (cfg_val > MAX_KEYS_DEF)
				n_eff = MAX_KEYS_DEF;
			else
				n_eff = int'(cfg_val);
			if (reload) begin
				load_track(n_eff);
				random_items += n_eff;
			end
			if (phase == 2) begin
				hold_off_req = 1'b1;
				n_items = 40;
			end else begin
				n_items = (n_eff > 64) ? 20 : $urandom_range(10, 30);
			end
			for (int j = 0; j < n_items; j++) begin
				if ($urandom_range(0, 99) < 12) begin
					// stray key rewrite: same time keeps order, a random one breaks it
					k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n_eff - 1)
						: $urandom_range(0, MAX_KEYS_DEF - 1);
					t = ($urandom_range(0, 1) == 0) ? gen_time[k] : $urandom;
					queue_key(k, t, rand_comp(), rand_comp(), rand_comp());
				end else begin
					queue_sample(pick_sample_time(n_eff));
				end
			end
			random_items += n_items;
			phase++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d samples (%0d interpolated, %0d held) after %0d key writes,",
			samples_checked, interp_seen, hold_seen, keys_written);
		$display("across %0d key_count settings with random gaps and one long output stall.",
			settings_used);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
